// ===== design/edd_pkg.sv =====
// Shared types, constants and the diffusion arithmetic of the error diffusion dither.
package edd_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int WIDTH_REG_W   = 11;
  localparam int HEIGHT_REG_W  = 13;
  localparam int ROW_W         = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [2:0] K_UPPER_LEFT  = 3'd1;
  localparam logic [2:0] K_UPPER       = 3'd5;
  localparam logic [2:0] K_UPPER_RIGHT = 3'd3;
  localparam logic [2:0] K_LEFT        = 3'd7;

  localparam logic [9:0] WHITE_THRESHOLD = 10'd383;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic white;
    logic frame_end;
  } result_t;

  typedef struct packed {
    logic signed [8:0] red;
    logic signed [8:0] green;
    logic signed [8:0] blue;
  } err3_t;

  localparam int ERR3_W = $bits(err3_t);

  // Computes v + k*e/16 with round-half-to-even and saturation to 0..255.
  function automatic logic [7:0] diffuse(input logic [7:0] v, input logic signed [8:0] e,
                                         input logic [2:0] k);
    logic signed [13:0] ke;
    logic signed [13:0] t;
    logic signed [9:0]  q;
    logic [3:0]         r;
    logic [7:0]         res;
    ke = $signed({{5{e[8]}}, e}) * $signed({11'b0, k});
    t  = $signed({2'b00, v, 4'b0000}) + ke;
    q  = t[13:4];
    r  = t[3:0];
    if ((r > 4'd8) || ((r == 4'd8) && q[0])) begin
      q = q + 10'sd1;
    end
    if (q < 10'sd0) begin
      res = 8'd0;
    end else if (q > 10'sd255) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

  // Error of one channel after the black or white decision.
  function automatic logic signed [8:0] quant_err(input logic [7:0] v, input logic white);
    logic [8:0] ext;
    ext = {1'b0, v};
    return white ? $signed(ext - 9'd255) : $signed(ext);
  endfunction

endpackage

// ===== design/edd_stream_if.sv =====
// Valid/ready stream interface that carries one payload of a given type.
interface edd_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/error_diffusion_dither_core.sv =====
// Floyd-Steinberg dither core: RGB pixels in raster order in, one white bit per pixel out.
// An accepted pixel passes through stages 1, 2 and 3 into the output register.
// Throughput is one pixel per cycle for rows of five or more pixels while the output is taken;
// narrower rows stall the input until the line store writes of the columns a pixel reads land.
// Reset clears the pipeline and counters and sets width 640 (at most MAX_WIDTH) and height 480; the line store
// is not cleared, since every entry is written one row before it is read.
module error_diffusion_dither_core #(
  parameter int MAX_WIDTH = edd_pkg::DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  edd_stream_if.sink                   in_pix,
  edd_stream_if.source                 out_res,
  input  logic                         cfg_we,
  input  logic [edd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import edd_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = CW + 1;
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

  logic [WW-1:0]           weff_r;
  logic [HEIGHT_REG_W-1:0] heff_r;
  logic [CW-1:0]           col_r;
  logic [ROW_W-1:0]        row_r;
  err3_t                   left_r;
  err3_t                   ul_r;

  logic                    s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  rgb_t                    s1_pix_r, s2_pix_r, s3_pix_r;
  logic [CW-1:0]           s1_x_r, s2_x_r, s3_x_r;
  logic                    s1_left_r, s2_left_r, s3_left_r;
  logic                    s1_up_r, s2_up_r;
  logic                    s1_ur_r, s2_ur_r;
  logic                    s1_end_r, s2_end_r, s3_end_r;
  err3_t                   s2_urerr_r;
  result_t                 out_data_r;

  logic                    adv;
  logic                    accept;
  logic                    hazard;
  logic [CW-1:0]           col_p1;
  logic                    has_ur;
  logic                    last_col;
  logic                    last_row;
  logic [WIDTH_REG_W-1:0]  w_in;
  logic [HEIGHT_REG_W-1:0] h_in;
  logic [WW-1:0]           w_clamped;
  logic [HEIGHT_REG_W-1:0] h_clamped;
  logic [ERR3_W-1:0]       rd_up, rd_ur;
  err3_t                   up_err, ur_err, new_err;
  rgb_t                    v1, v2, v3;
  logic [9:0]              chan_sum;
  logic                    white;

  // Configuration values are clamped to the supported range when written.
  assign w_in = cfg_data[WIDTH_REG_W-1:0];
  assign h_in = cfg_data[HEIGHT_REG_W-1:0];

  always_comb begin
    if (w_in == '0) begin
      w_clamped = WW'(1);
    end else if (int'(w_in) > MAX_WIDTH) begin
      w_clamped = WW'(MAX_WIDTH);
    end else begin
      w_clamped = WW'(w_in);
    end
    if (h_in == '0) begin
      h_clamped = HEIGHT_REG_W'(1);
    end else if (int'(h_in) > MAX_HEIGHT) begin
      h_clamped = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_clamped = h_in;
    end
  end

  assign col_p1   = col_r + 1'b1;
  assign has_ur   = (({1'b0, col_r} + 1'b1) < weff_r);
  assign last_col = (({1'b0, col_r} + 1'b1) == weff_r);
  assign last_row = (({1'b0, row_r} + 1'b1) == heff_r);

  // A pixel waits while an older pixel that still has to write its line store entry
  // owns a column that this pixel reads.
  always_comb begin
    hazard = 1'b0;
    if (row_r != '0) begin
      if (s1_valid_r && ((s1_x_r == col_r) || (has_ur && (s1_x_r == col_p1)))) begin
        hazard = 1'b1;
      end
      if (s2_valid_r && ((s2_x_r == col_r) || (has_ur && (s2_x_r == col_p1)))) begin
        hazard = 1'b1;
      end
      if (s3_valid_r && ((s3_x_r == col_r) || (has_ur && (s3_x_r == col_p1)))) begin
        hazard = 1'b1;
      end
    end
  end

  assign adv          = !out_valid_r || out_res.ready;
  assign in_pix.ready = adv && !hazard;
  assign accept       = in_pix.valid && in_pix.ready;

  edd_ram #(
    .WIDTH (ERR3_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .we      (adv && s3_valid_r),
    .waddr   (s3_x_r),
    .wdata   (new_err),
    .re      (accept),
    .raddr_a (col_r),
    .raddr_b (col_p1),
    .rdata_a (rd_up),
    .rdata_b (rd_ur)
  );

  assign up_err = rd_up;
  assign ur_err = rd_ur;

  // Stage 1: upper-left and upper contributions.
  always_comb begin
    v1 = s1_pix_r;
    if (s1_up_r) begin
      if (s1_left_r) begin
        v1.red   = diffuse(v1.red,   ul_r.red,   K_UPPER_LEFT);
        v1.green = diffuse(v1.green, ul_r.green, K_UPPER_LEFT);
        v1.blue  = diffuse(v1.blue,  ul_r.blue,  K_UPPER_LEFT);
      end
      v1.red   = diffuse(v1.red,   up_err.red,   K_UPPER);
      v1.green = diffuse(v1.green, up_err.green, K_UPPER);
      v1.blue  = diffuse(v1.blue,  up_err.blue,  K_UPPER);
    end
  end

  // Stage 2: upper-right contribution.
  always_comb begin
    v2 = s2_pix_r;
    if (s2_up_r && s2_ur_r) begin
      v2.red   = diffuse(v2.red,   s2_urerr_r.red,   K_UPPER_RIGHT);
      v2.green = diffuse(v2.green, s2_urerr_r.green, K_UPPER_RIGHT);
      v2.blue  = diffuse(v2.blue,  s2_urerr_r.blue,  K_UPPER_RIGHT);
    end
  end

  // Stage 3: left contribution, decision and new error.
  always_comb begin
    v3 = s3_pix_r;
    if (s3_left_r) begin
      v3.red   = diffuse(v3.red,   left_r.red,   K_LEFT);
      v3.green = diffuse(v3.green, left_r.green, K_LEFT);
      v3.blue  = diffuse(v3.blue,  left_r.blue,  K_LEFT);
    end
    chan_sum      = {2'b00, v3.red} + {2'b00, v3.green} + {2'b00, v3.blue};
    white         = (chan_sum >= WHITE_THRESHOLD);
    new_err.red   = quant_err(v3.red,   white);
    new_err.green = quant_err(v3.green, white);
    new_err.blue  = quant_err(v3.blue,  white);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weff_r      <= WW'(RST_W);
      heff_r      <= HEIGHT_REG_W'(RESET_HEIGHT);
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      ul_r        <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_WIDTH:  weff_r <= w_clamped;
          CFG_IDX_HEIGHT: heff_r <= h_clamped;
          default: ;
        endcase
        col_r  <= '0;
        row_r  <= '0;
        left_r <= '0;
        ul_r   <= '0;
      end else begin
        if (accept) begin
          if (last_col) begin
            col_r <= '0;
            row_r <= last_row ? '0 : row_r + 1'b1;
          end else begin
            col_r <= col_p1;
          end
        end
        if (adv && s1_valid_r) begin
          ul_r <= up_err;
        end
        if (adv && s3_valid_r) begin
          left_r <= new_err;
        end
      end
      if (adv) begin
        s1_valid_r  <= accept;
        s2_valid_r  <= s1_valid_r;
        s3_valid_r  <= s2_valid_r;
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r   <= in_pix.data;
      s1_x_r     <= col_r;
      s1_left_r  <= (col_r != '0);
      s1_up_r    <= (row_r != '0);
      s1_ur_r    <= has_ur;
      s1_end_r   <= last_col && last_row;

      s2_pix_r   <= v1;
      s2_x_r     <= s1_x_r;
      s2_left_r  <= s1_left_r;
      s2_up_r    <= s1_up_r;
      s2_ur_r    <= s1_ur_r;
      s2_end_r   <= s1_end_r;
      s2_urerr_r <= ur_err;

      s3_pix_r   <= v2;
      s3_x_r     <= s2_x_r;
      s3_left_r  <= s2_left_r;
      s3_end_r   <= s2_end_r;

      out_data_r.white     <= white;
      out_data_r.frame_end <= s3_end_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

endmodule

// ===== design/edd_ram.sv =====
// Generic simple dual-port RAM with one write port and two registered read ports.
module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
